>>> rtl/srls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srls_pkg
// Shared types and constants of the sensor record log.
// ----------------------------------------------------------------------------
package srls_pkg;

	localparam int DEPTH = 16;
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int MAX_RESULTS = 32;
	localparam int SECS_PER_HOUR = 60 * 60;
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		OP_STORE = 2'd0,
		OP_STATS = 2'd1,
		OP_CHECK = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_STORED  = 3'd0,
		K_STATS   = 3'd1,
		K_NONE    = 3'd2,
		K_TEMP_HI = 3'd3,
		K_LUM_LO  = 3'd4,
		K_NO_VIOL = 3'd5
	} kind_t;

	localparam logic CFG_TEMP = 1'b0;
	localparam logic CFG_LUM  = 1'b1;

	typedef struct packed {
		op_t         op;
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic [7:0]  temperature;
		logic [7:0]  luminosity;
		logic [16:0] window_low;
		logic [16:0] window_high;
	} cmd_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  slot_index;
		logic [7:0]  reading;
		logic [4:0]  record_count;
		logic [7:0]  temp_max;
		logic [7:0]  temp_min;
		logic [15:0] temp_mean;
		logic [7:0]  lum_max;
		logic [7:0]  lum_min;
		logic [15:0] lum_mean;
		logic        last;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_CHECK,
		ST_EMIT
	} state_t;

endpackage

>>> rtl/srls_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srls_queue
// Small FIFO of decoded commands between the front and back ends.
// ----------------------------------------------------------------------------
module srls_queue
	import srls_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic empty
);
	cmd_t mem_q [QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'(QDEPTH));
	assign empty = (cnt_q == 2'd0);
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end
endmodule

>>> rtl/srls_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srls_engine
// Back end: record ring, slot scan, serial divider and check walk.
// ----------------------------------------------------------------------------
module srls_engine
	import srls_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	input  logic [7:0] temp_thr,
	input  logic [7:0] lum_thr,
	output logic       res_valid,
	input  logic       res_ready,
	output res_t       res
);
	// ring with per-slot valid bits (empty slot reads zero)
	logic [32:0] store_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [SLOT_W-1:0] wslot_q;
	logic [CNT_W-1:0] fill_q, unchk_q;

	state_t state_q, state_d;
	cmd_t cur_q;
	logic [SLOT_W-1:0] idx_q;
	logic [4:0] cnt_q;
	logic [CNT_W-1:0] kfull_q;
	logic [7:0] tmax_q, tmin_q, lmax_q, lmin_q;
	logic [CNT_W+7:0] st_q, sl_q;
	logic [5:0] nres_q;
	logic phase_q;

	// one violation held back until it is known whether it is the last
	res_t hold_q;
	logic hold_v_q;

	// divider: restoring, one quotient bit per cycle, both means in parallel
	localparam int NW = CNT_W + 16;
	logic [NW-1:0] tq_q, lq_q;
	logic [CNT_W:0] trem_q, lrem_q;
	logic [4:0] dcnt_q;

	res_t out_q;
	logic out_v_q;
	assign res = out_q;
	assign res_valid = out_v_q;
	logic out_free;
	assign out_free = !out_v_q || res_ready;
	logic out_load;
	res_t out_nxt;

	// scan view of current slot
	logic [32:0] rec;
	logic [16:0] ts;
	logic hit;
	logic [7:0] rt, rl;
	assign rec = vld_q[idx_q] ? store_q[idx_q] : 33'd0;
	assign rt = rec[24:17];
	assign rl = rec[32:25];
	assign ts = 17'(rec[4:0]) * 17'(SECS_PER_HOUR) + 17'(rec[10:5]) * 17'd60
		+ 17'(rec[16:11]);
	assign hit = (ts > cur_q.window_low) && (ts < cur_q.window_high) && (ts != 17'd0);

	// check view
	logic [SLOT_W-1:0] cslot;
	logic [32:0] crec;
	logic t_bad, l_bad;
	logic chk_done, viol;
	res_t viol_res;
	assign cslot = SLOT_W'(wslot_q + SLOT_W'(1) - SLOT_W'(unchk_q));
	assign crec = vld_q[cslot] ? store_q[cslot] : 33'd0;
	assign t_bad = crec[24:17] > temp_thr;
	assign l_bad = crec[32:25] < lum_thr;
	// a new record is taken only while two more results still fit
	assign chk_done = !phase_q && (unchk_q == '0 || nres_q + 6'd2 > 6'(MAX_RESULTS));
	assign viol = phase_q ? l_bad : t_bad;

	always_comb begin
		viol_res = '0;
		viol_res.slot_index = 4'(cslot);
		if (phase_q) begin
			viol_res.kind = K_LUM_LO;
			viol_res.reading = crec[32:25];
		end else begin
			viol_res.kind = K_TEMP_HI;
			viol_res.reading = crec[24:17];
		end
	end

	logic [CNT_W:0] ttr, ltr;
	assign ttr = {trem_q[CNT_W-1:0], tq_q[NW-1]};
	assign ltr = {lrem_q[CNT_W-1:0], lq_q[NW-1]};

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		out_load = 1'b0;
		out_nxt = '0;
		case (state_q)
			ST_IDLE: if (cmd_valid) begin
				cmd_pop = 1'b1;
				case (cmd.op)
					OP_STORE: state_d = ST_EMIT;
					OP_STATS: state_d = ST_SCAN;
					OP_CHECK: state_d = ST_CHECK;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_SCAN: if (idx_q == SLOT_W'(DEPTH - 1)) state_d = ST_DIV;
			ST_DIV: if (dcnt_q == 5'd0 || kfull_q == '0) state_d = ST_EMIT;
			ST_CHECK: if (out_free) begin
				if (chk_done) begin
					// close the walk: held violation or a no-violation word
					out_load = 1'b1;
					if (hold_v_q) out_nxt = hold_q;
					else out_nxt.kind = K_NO_VIOL;
					out_nxt.last = 1'b1;
					state_d = ST_IDLE;
				end else if (viol && hold_v_q) begin
					// a newer violation exists, so the held one is not last
					out_load = 1'b1;
					out_nxt = hold_q;
				end
			end
			ST_EMIT: if (out_free) begin
				out_load = 1'b1;
				out_nxt.last = 1'b1;
				if (cur_q.op == OP_STORE) begin
					out_nxt.kind = K_STORED;
					out_nxt.slot_index = 4'(wslot_q);
				end else if (kfull_q == '0) begin
					out_nxt.kind = K_NONE;
				end else begin
					out_nxt.kind = K_STATS;
					out_nxt.record_count = cnt_q;
					out_nxt.temp_max = tmax_q;
					out_nxt.temp_min = tmin_q;
					out_nxt.lum_max = lmax_q;
					out_nxt.lum_min = lmin_q;
					out_nxt.temp_mean = tq_q[15:0];
					out_nxt.lum_mean = lq_q[15:0];
				end
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) cur_q <= cmd;
		if (state_q == ST_EMIT && out_free && cur_q.op == OP_STORE)
			store_q[wslot_q] <= {cur_q.luminosity, cur_q.temperature, cur_q.seconds,
				cur_q.minutes, cur_q.hours};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_q <= '0;
			wslot_q <= SLOT_W'(DEPTH - 1);
			fill_q <= '0;
			unchk_q <= '0;
			out_v_q <= 1'b0;
			out_q <= '0;
			hold_q <= '0;
			hold_v_q <= 1'b0;
			idx_q <= '0; cnt_q <= '0; kfull_q <= '0;
			tmax_q <= '0; tmin_q <= '0; lmax_q <= '0; lmin_q <= '0;
			st_q <= '0; sl_q <= '0; nres_q <= '0; phase_q <= 1'b0;
			tq_q <= '0; lq_q <= '0; trem_q <= '0; lrem_q <= '0; dcnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_q <= out_nxt;
				out_v_q <= 1'b1;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0; cnt_q <= '0; kfull_q <= '0;
					tmax_q <= '0; lmax_q <= '0; tmin_q <= 8'd255; lmin_q <= 8'd255;
					st_q <= '0; sl_q <= '0; nres_q <= '0; phase_q <= 1'b0;
					hold_v_q <= 1'b0;
					if (cmd_valid && cmd.op == OP_STORE)
						wslot_q <= SLOT_W'(wslot_q + SLOT_W'(1));
				end
				ST_SCAN: begin
					idx_q <= SLOT_W'(idx_q + SLOT_W'(1));
					if (hit) begin
						kfull_q <= CNT_W'(kfull_q + CNT_W'(1));
						if (cnt_q != 5'd31) cnt_q <= cnt_q + 5'd1;
						st_q <= st_q + (CNT_W+8)'(rt);
						sl_q <= sl_q + (CNT_W+8)'(rl);
						if (rt > tmax_q) tmax_q <= rt;
						if (rt < tmin_q) tmin_q <= rt;
						if (rl > lmax_q) lmax_q <= rl;
						if (rl < lmin_q) lmin_q <= rl;
					end
					if (idx_q == SLOT_W'(DEPTH - 1)) begin
						tq_q <= NW'({st_q + (CNT_W+8)'(hit ? rt : 8'd0), 8'd0});
						lq_q <= NW'({sl_q + (CNT_W+8)'(hit ? rl : 8'd0), 8'd0});
						trem_q <= '0; lrem_q <= '0;
						dcnt_q <= 5'(NW);
					end
				end
				ST_DIV: if (dcnt_q != 5'd0 && kfull_q != '0) begin
					dcnt_q <= dcnt_q - 5'd1;
					if (ttr >= (CNT_W+1)'(kfull_q)) begin
						trem_q <= ttr - (CNT_W+1)'(kfull_q);
						tq_q <= {tq_q[NW-2:0], 1'b1};
					end else begin
						trem_q <= ttr;
						tq_q <= {tq_q[NW-2:0], 1'b0};
					end
					if (ltr >= (CNT_W+1)'(kfull_q)) begin
						lrem_q <= ltr - (CNT_W+1)'(kfull_q);
						lq_q <= {lq_q[NW-2:0], 1'b1};
					end else begin
						lrem_q <= ltr;
						lq_q <= {lq_q[NW-2:0], 1'b0};
					end
				end
				// check walk: temperature in phase 0, luminosity in phase 1
				ST_CHECK: if (out_free) begin
					if (chk_done) begin
						hold_v_q <= 1'b0;
					end else begin
						if (viol) begin
							hold_q <= viol_res;
							hold_v_q <= 1'b1;
							nres_q <= nres_q + 6'd1;
						end
						if (phase_q) unchk_q <= CNT_W'(unchk_q - CNT_W'(1));
						phase_q <= ~phase_q;
					end
				end
				ST_EMIT: if (out_free && cur_q.op == OP_STORE) begin
					vld_q[wslot_q] <= 1'b1;
					if (fill_q != CNT_W'(DEPTH)) fill_q <= CNT_W'(fill_q + CNT_W'(1));
					if (unchk_q != CNT_W'(DEPTH)) unchk_q <= CNT_W'(unchk_q + CNT_W'(1));
				end
				default: ;
			endcase
		end
	end
endmodule

>>> rtl/sensor_record_log_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_record_log_stats
// Ring log of timestamped sensor records with window statistics and checks.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command word (store, statistics, check); m_axis
//   returns result words, tlast on the final result of each command.
//   A front end accepts words into a two-entry queue; the back end runs
//   them one at a time, so commands can be queued while the back end works.
//   Steps from acceptance to the result word, receiver never stalling:
//   Store: pop, result load. Statistics: pop, a scan of all DEPTH slots
//   (one slot per cycle), 21 restoring divide steps for both means, an
//   exit step and the result load; the divide steps are skipped when no
//   record is in the window. Check: pop, a temperature and a luminosity
//   step per unchecked record, a closing step; one word at most per cycle.
//   The back end takes the next command the cycle after its last result load.
//   The result register holds its word while m_axis_tready is low; the back
//   end then waits and the queue fills, dropping s_axis_tready.
//   Reset clears the ring (valid bits) and counters and sets the thresholds (28, 4).
//   Threshold writes take effect the next cycle.
// ----------------------------------------------------------------------------
module sensor_record_log_stats
	import srls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// opcode, hours, minutes, seconds, temperature, luminosity, window_low, window_high
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// kind, slot_index, reading, record_count, temp_max, temp_min, temp_mean,
	// lum_max, lum_min, lum_mean
	output logic [87:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	logic [7:0] temp_thr_q, lum_thr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_thr_q <= 8'd28;
			lum_thr_q <= 8'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TEMP: temp_thr_q <= cfg_data;
				CFG_LUM:  lum_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front end: unpack word; unused opcode is dropped here
	cmd_t in_cmd;
	assign in_cmd.op          = op_t'(s_axis_tdata[1:0]);
	assign in_cmd.hours       = s_axis_tdata[6:2];
	assign in_cmd.minutes     = s_axis_tdata[12:7];
	assign in_cmd.seconds     = s_axis_tdata[18:13];
	assign in_cmd.temperature = s_axis_tdata[26:19];
	assign in_cmd.luminosity  = s_axis_tdata[34:27];
	assign in_cmd.window_low  = s_axis_tdata[51:35];
	assign in_cmd.window_high = s_axis_tdata[68:52];

	logic q_full, q_empty, q_pop;
	cmd_t q_cmd;
	assign s_axis_tready = !q_full;

	srls_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(s_axis_tvalid && in_cmd.op != OP_NONE), .push_data(in_cmd),
		.full(q_full), .pop(q_pop), .pop_data(q_cmd), .empty(q_empty)
	);

	res_t r;
	srls_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(!q_empty), .cmd(q_cmd), .cmd_pop(q_pop),
		.temp_thr(temp_thr_q), .lum_thr(lum_thr_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(r)
	);

	assign m_axis_tdata = {4'd0, r.lum_mean, r.lum_min, r.lum_max, r.temp_mean,
		r.temp_min, r.temp_max, r.record_count, r.reading, r.slot_index, r.kind};
	assign m_axis_tlast = r.last;

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	ap_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !s_axis_tready)
		else $error("ready while queue full");
endmodule
